// ===== design/mlfs_pkg.sv =====
// Package for the memory LCD frame serializer.
// Holds item and queue entry types, register indexes and the bit reverse helper.
// No dependencies.
package mlfs_pkg;

    localparam int MAX_LINE_BYTES = 64;
    localparam int LB_W           = 7;
    localparam int BYTE_IDX_W     = 6;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 8;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_W    = 2;
    localparam int QUEUE_CNT_W    = 3;
    localparam int SLOT_N         = 5;

    localparam logic [7:0]      WRITE_CMD_RESET  = 8'd128;
    localparam logic [7:0]      CLEAR_CMD_RESET  = 8'd32;
    localparam logic [7:0]      FRAME_ROWS_RESET = 8'd168;
    localparam logic [LB_W-1:0] LINE_BYTES_RESET = 7'd18;
    localparam logic [LB_W-1:0] LINE_BYTES_MAX   = LB_W'(MAX_LINE_BYTES);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WRITE_CMD  = 2'd0,
        REG_CLEAR_CMD  = 2'd1,
        REG_FRAME_ROWS = 2'd2,
        REG_LINE_BYTES = 2'd3
    } cfg_index_t;

    typedef enum int {
        SLOT_CMD   = 0,
        SLOT_LINE  = 1,
        SLOT_DATA  = 2,
        SLOT_DUMMY = 3,
        SLOT_CLOSE = 4
    } slot_t;

    typedef struct packed {
        logic       func;
        logic [7:0] pixel_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] spi_byte;
        logic       select_release;
        logic       last;
    } out_t;

    typedef struct packed {
        logic [7:0]        cmd_byte;
        logic [7:0]        line_byte;
        logic [7:0]        data_byte;
        logic [SLOT_N-1:0] slots;
    } entry_t;

    function automatic logic [7:0] bit_reverse8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

endpackage

// ===== design/mlfs_front.sv =====
// Front part of the memory LCD frame serializer.
// Holds the configuration registers and frame position, classifies each item into a queue entry.
// Depends on mlfs_pkg.
module mlfs_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [mlfs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mlfs_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  mlfs_pkg::in_t                      in_item,
    output logic                               q_wr_valid,
    input  logic                               q_wr_ready,
    output mlfs_pkg::entry_t                   q_wr_entry
);
    import mlfs_pkg::*;

    logic [7:0]            write_cmd_reg;
    logic [7:0]            clear_cmd_reg;
    logic [7:0]            frame_rows_reg;
    logic [LB_W-1:0]       line_bytes_reg;
    logic [7:0]            line_index_reg;
    logic [7:0]            line_index_next;
    logic [BYTE_IDX_W-1:0] byte_index_reg;
    logic [BYTE_IDX_W-1:0] byte_index_next;
    logic                  in_frame_reg;
    logic                  in_frame_next;

    logic [7:0]            rows;
    logic [LB_W-1:0]       lb;
    logic [7:0]            li;
    logic [BYTE_IDX_W-1:0] bi;
    logic                  line_end;
    logic                  frame_end;
    logic                  accept;
    logic                  drop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_cmd_reg  <= WRITE_CMD_RESET;
            clear_cmd_reg  <= CLEAR_CMD_RESET;
            frame_rows_reg <= FRAME_ROWS_RESET;
            line_bytes_reg <= LINE_BYTES_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index_t'(cfg_index))
                REG_WRITE_CMD:  write_cmd_reg  <= cfg_data;
                REG_CLEAR_CMD:  clear_cmd_reg  <= cfg_data;
                REG_FRAME_ROWS: frame_rows_reg <= cfg_data;
                REG_LINE_BYTES: line_bytes_reg <= cfg_data[LB_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        rows = (frame_rows_reg == 8'd0) ? 8'd1 : frame_rows_reg;
        if (line_bytes_reg == '0)
            lb = LB_W'(1);
        else if (line_bytes_reg > LINE_BYTES_MAX)
            lb = LINE_BYTES_MAX;
        else
            lb = line_bytes_reg;

        li        = in_frame_reg ? line_index_reg : 8'd0;
        bi        = in_frame_reg ? byte_index_reg : '0;
        line_end  = ({1'b0, bi} + LB_W'(1)) >= lb;
        frame_end = ({1'b0, li} + 9'd1) >= {1'b0, rows};

        drop       = in_item.func && in_frame_reg;
        in_ready   = q_wr_ready;
        accept     = in_valid && in_ready;
        q_wr_valid = in_valid && !drop;

        q_wr_entry           = '0;
        q_wr_entry.line_byte = bit_reverse8(li + 8'd1);
        q_wr_entry.data_byte = ~in_item.pixel_byte;
        if (in_item.func)
        begin
            q_wr_entry.cmd_byte          = clear_cmd_reg;
            q_wr_entry.slots[SLOT_CMD]   = 1'b1;
            q_wr_entry.slots[SLOT_DUMMY] = 1'b1;
            q_wr_entry.slots[SLOT_CLOSE] = 1'b1;
        end
        else
        begin
            q_wr_entry.cmd_byte          = write_cmd_reg;
            q_wr_entry.slots[SLOT_CMD]   = !in_frame_reg;
            q_wr_entry.slots[SLOT_LINE]  = (bi == '0);
            q_wr_entry.slots[SLOT_DATA]  = 1'b1;
            q_wr_entry.slots[SLOT_DUMMY] = line_end;
            q_wr_entry.slots[SLOT_CLOSE] = line_end && frame_end;
        end

        line_index_next = line_index_reg;
        byte_index_next = byte_index_reg;
        in_frame_next   = in_frame_reg;
        if (accept && !in_item.func)
        begin
            if (line_end)
            begin
                byte_index_next = '0;
                if (frame_end)
                begin
                    line_index_next = 8'd0;
                    in_frame_next   = 1'b0;
                end
                else
                begin
                    line_index_next = li + 8'd1;
                    in_frame_next   = 1'b1;
                end
            end
            else
            begin
                byte_index_next = bi + BYTE_IDX_W'(1);
                line_index_next = li;
                in_frame_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_index_reg <= 8'd0;
            byte_index_reg <= '0;
            in_frame_reg   <= 1'b0;
        end
        else
        begin
            line_index_reg <= line_index_next;
            byte_index_reg <= byte_index_next;
            in_frame_reg   <= in_frame_next;
        end
    end

endmodule

// ===== design/mlfs_queue.sv =====
// Short entry queue between the front and back parts of the serializer.
// Depends on mlfs_pkg.
module mlfs_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  mlfs_pkg::entry_t wr_entry,
    output logic             rd_valid,
    input  logic             rd_ready,
    output mlfs_pkg::entry_t rd_entry
);
    import mlfs_pkg::*;

    entry_t                 slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   push;
    logic                   pop;

    assign wr_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_entry = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QUEUE_CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QUEUE_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

// ===== design/mlfs_back.sv =====
// Back part: expands each queue entry into link bytes, one per cycle unless stalled.
// Depends on mlfs_pkg.
module mlfs_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_rd_valid,
    output logic             q_rd_ready,
    input  mlfs_pkg::entry_t q_rd_entry,
    output logic             out_valid,
    input  logic             out_ready,
    output mlfs_pkg::out_t   out_item
);
    import mlfs_pkg::*;

    entry_t            cur_reg;
    logic [SLOT_N-1:0] mask_reg;
    logic [SLOT_N-1:0] mask_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_t              out_reg;
    out_t              out_next;

    logic [SLOT_N-1:0] pick;
    logic [SLOT_N-1:0] rest;
    logic              emit;
    logic              load;

    always_comb
    begin
        pick = mask_reg & (~mask_reg + SLOT_N'(1));
        rest = mask_reg & ~pick;
        emit = (mask_reg != '0) && (!out_valid_reg || out_ready);
        load = (mask_reg == '0) || (emit && rest == '0);
        q_rd_ready = load;

        out_next = out_reg;
        out_next.select_release = 1'b0;
        out_next.last           = (rest == '0);
        if (pick[SLOT_CMD])
            out_next.spi_byte = cur_reg.cmd_byte;
        else if (pick[SLOT_LINE])
            out_next.spi_byte = cur_reg.line_byte;
        else if (pick[SLOT_DATA])
            out_next.spi_byte = cur_reg.data_byte;
        else
        begin
            out_next.spi_byte       = 8'd0;
            out_next.select_release = pick[SLOT_CLOSE];
        end

        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;

        mask_next = emit ? rest : mask_reg;
        if (load)
            mask_next = q_rd_valid ? q_rd_entry.slots : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && q_rd_valid)
            cur_reg <= q_rd_entry;
        if (emit)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// ===== design/memory_lcd_frame_serializer.sv =====
// Top level of the memory LCD frame serializer: front, entry queue and back.
// Depends on mlfs_pkg, mlfs_front, mlfs_queue, mlfs_back.
//
// Each item is classified as it is accepted and put into a four-entry queue; the back part
// then sends the bytes it causes on the output channel, one byte per cycle while out_ready
// does not stall it. A run of plain pixel bytes goes through at one item per cycle when the
// output is not stalled; a write command, line header, dummy or frame close adds one extra
// byte each. The first byte of an item passes through the queue slot, the back part's
// current entry register and the output register before it appears. A clear item arriving
// while a frame is open is accepted and dropped. Configuration is taken at the next clock
// edge and applies to items accepted afterward.
module memory_lcd_frame_serializer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [mlfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mlfs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  mlfs_pkg::in_t                   in_item,
    output logic                            out_valid,
    input  logic                            out_ready,
    output mlfs_pkg::out_t                  out_item
);
    import mlfs_pkg::*;

    logic   q_wr_valid;
    logic   q_wr_ready;
    entry_t q_wr_entry;
    logic   q_rd_valid;
    logic   q_rd_ready;
    entry_t q_rd_entry;

    mlfs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .q_wr_valid (q_wr_valid),
        .q_wr_ready (q_wr_ready),
        .q_wr_entry (q_wr_entry)
    );

    mlfs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_entry (q_wr_entry),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_entry (q_rd_entry)
    );

    mlfs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_rd_valid (q_rd_valid),
        .q_rd_ready (q_rd_ready),
        .q_rd_entry (q_rd_entry),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule
